// File: sv/buddy_page_allocator_unit_macros.svh
// Assertion helpers for the allocator top level
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// Condition in one cycle implies consequence in the next
`define BPA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition implies consequence in the same cycle
`define BPA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/bpa_pkg.sv
`default_nettype none
package bpa_pkg;

   // Field widths
   localparam int IDX_W = 12;
   localparam int CNT_W = 13;

   // Free-head flags are stored 16 to a row
   localparam int FLAG_W  = 16;
   localparam int FLAG_SH = 4;

   // Operation codes
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_INIT  = 2'd2;

   // Sequencer steps, also used as the datapath command
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_RCLR   = 5'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 5'd1;
   localparam logic [ST_W-1:0] ST_DISP   = 5'd2;
   localparam logic [ST_W-1:0] ST_FAIL   = 5'd3;
   localparam logic [ST_W-1:0] ST_CLR    = 5'd4;
   localparam logic [ST_W-1:0] ST_AK     = 5'd5;
   localparam logic [ST_W-1:0] ST_SRCH   = 5'd6;
   localparam logic [ST_W-1:0] ST_SPLIT  = 5'd7;
   localparam logic [ST_W-1:0] ST_FR     = 5'd8;
   localparam logic [ST_W-1:0] ST_FRK    = 5'd9;
   localparam logic [ST_W-1:0] ST_OV_RD  = 5'd10;
   localparam logic [ST_W-1:0] ST_OV_CK  = 5'd11;
   localparam logic [ST_W-1:0] ST_OV2_RD = 5'd12;
   localparam logic [ST_W-1:0] ST_OV2_CK = 5'd13;
   localparam logic [ST_W-1:0] ST_M_TEST = 5'd14;
   localparam logic [ST_W-1:0] ST_M_CK   = 5'd15;
   localparam logic [ST_W-1:0] ST_M_UP   = 5'd16;
   localparam logic [ST_W-1:0] ST_U_RD   = 5'd17;
   localparam logic [ST_W-1:0] ST_U_W    = 5'd18;
   localparam logic [ST_W-1:0] ST_P_RD   = 5'd19;
   localparam logic [ST_W-1:0] ST_P_W    = 5'd20;
   localparam logic [ST_W-1:0] ST_P_W2   = 5'd21;
   localparam logic [ST_W-1:0] ST_FNX    = 5'd22;
   localparam logic [ST_W-1:0] ST_DONE   = 5'd23;

   typedef struct packed {
      logic [ST_W-1:0] op;
      logic            accept;
      logic            rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       free_go;
      logic       alloc_bad;
      logic       clr_last;
      logic       ak_more;
      logic       head_hit;
      logic       c_last;
      logic       split_more;
      logic       n_zero;
      logic       frk_more;
      logic       ov_hit;
      logic       ov_last;
      logic       ov2_hit;
      logic       j_last;
      logic       m_try;
      logic       m_hit;
      logic       rsp_free;
   } status_type;

endpackage
`default_nettype wire

// File: sv/buddy_page_allocator_unit.sv
// Buddy page allocator over one region of up to PAGES pages.
// Request channel (req_*): func selects allocate, free or initialize;
// first_page is the first page to free, num_pages the size of the request.
// Response channel (rsp_*): one transaction per request with ok, the first
// allocated page and the total of free pages after the operation.
// One request is in work at a time. Rejected requests and unused codes go
// straight to the response. Per released block the sequencer steps up the
// orders, reads and checks each 16-page flag row of the block, checks each
// order for an enclosing free block and merges with its buddy (test, check,
// unlink, update); single-port link, order and flag memories set this pace.
// An initialize request first clears the flag memory, one 16-page row per
// cycle, then loads the region.
// After reset the same clearing pass runs before req_ready first rises.
// The result sits in an output register; a new request is taken while it
// waits. If rsp_ready stays low the next result holds the sequencer until
// the register frees up.
`default_nettype none
`include "buddy_page_allocator_unit_macros.svh"
module buddy_page_allocator_unit import bpa_pkg::*; #(
   parameter int PAGES       = 4096,
   parameter int MAX_ORDER_P = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_func,
   input  wire logic [IDX_W-1:0] req_first_page,
   input  wire logic [CNT_W-1:0] req_num_pages,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_ok,
   output logic [IDX_W-1:0]      rsp_alloc_index,
   output logic [CNT_W-1:0]      rsp_free_total
);

   cmd_type    cmd;
   status_type st;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .st        (st),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   bpa_dpath #(
      .PAGES       (PAGES),
      .MAX_ORDER_P (MAX_ORDER_P)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_first_page  (req_first_page),
      .req_num_pages   (req_num_pages),
      .st              (st),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_alloc_index (rsp_alloc_index),
      .rsp_free_total  (rsp_free_total)
   );

   // Checks
   `BPA_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `BPA_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_alloc_index == '0, "failed allocation with nonzero index")
   `BPA_ASSERT_SAME(a_total_bound, clock, reset, rsp_valid, int'(rsp_free_total) <= PAGES, "free total above page count")

endmodule
`default_nettype wire

// File: sv/bpa_ctrl.sv
`default_nettype none
module bpa_ctrl import bpa_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type st,
   output cmd_type         cmd,
   output logic            req_ready
);

   logic [ST_W-1:0] state_ff, state_in;
   logic [ST_W-1:0] ret_ff, ret_in;

   // Handshake and command
   assign req_ready    = (state_ff == ST_IDLE);
   assign cmd.op       = state_ff;
   assign cmd.accept   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.rsp_load = (state_ff == ST_DONE) && st.rsp_free;

   // Next step
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      unique case (state_ff)
         ST_RCLR:   if (st.clr_last) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_DISP;
         ST_DISP: begin
            unique case (st.func)
               FUNC_INIT:  state_in = ST_CLR;
               FUNC_FREE:  state_in = st.free_go ? ST_FR : ST_DONE;
               FUNC_ALLOC: state_in = st.alloc_bad ? ST_FAIL : ST_AK;
               default:    state_in = ST_DONE;
            endcase
         end
         ST_FAIL:   state_in = ST_DONE;
         ST_CLR:    if (st.clr_last) state_in = ST_FR;
         ST_AK:     if (!st.ak_more) state_in = ST_SRCH;
         ST_SRCH: begin
            if (st.head_hit) begin
               state_in = ST_U_RD;
               ret_in   = ST_SPLIT;
            end else if (st.c_last) begin
               state_in = ST_FAIL;
            end
         end
         ST_SPLIT: begin
            if (st.split_more) begin
               state_in = ST_P_RD;
               ret_in   = ST_SPLIT;
            end else begin
               state_in = ST_FR;
            end
         end
         ST_FR:     state_in = st.n_zero ? ST_DONE : ST_FRK;
         ST_FRK:    if (!st.frk_more) state_in = ST_OV_RD;
         ST_OV_RD:  state_in = ST_OV_CK;
         ST_OV_CK: begin
            priority if (st.ov_hit) state_in = ST_FNX;
            else if (st.ov_last)    state_in = ST_OV2_RD;
            else                    state_in = ST_OV_RD;
         end
         ST_OV2_RD: state_in = ST_OV2_CK;
         ST_OV2_CK: begin
            priority if (st.ov2_hit) state_in = ST_FNX;
            else if (st.j_last)      state_in = ST_M_TEST;
            else                     state_in = ST_OV2_RD;
         end
         ST_M_TEST: begin
            if (st.m_try) begin
               state_in = ST_M_CK;
            end else begin
               state_in = ST_P_RD;
               ret_in   = ST_FNX;
            end
         end
         ST_M_CK: begin
            if (st.m_hit) begin
               state_in = ST_U_RD;
               ret_in   = ST_M_UP;
            end else begin
               state_in = ST_P_RD;
               ret_in   = ST_FNX;
            end
         end
         ST_M_UP:   state_in = ST_M_TEST;
         ST_U_RD:   state_in = ST_U_W;
         ST_U_W:    state_in = ret_ff;
         ST_P_RD:   state_in = ST_P_W;
         ST_P_W:    state_in = ST_P_W2;
         ST_P_W2:   state_in = ret_ff;
         ST_FNX:    state_in = ST_FR;
         ST_DONE:   if (st.rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RCLR;
         ret_ff   <= ST_FNX;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/bpa_dpath.sv
`default_nettype none
module bpa_dpath import bpa_pkg::*; #(
   parameter int PAGES       = 4096,
   parameter int MAX_ORDER_P = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cmd_type          cmd,
   input  wire logic [1:0]       req_func,
   input  wire logic [IDX_W-1:0] req_first_page,
   input  wire logic [CNT_W-1:0] req_num_pages,
   output status_type            st,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic [IDX_W-1:0]      rsp_alloc_index,
   output logic [CNT_W-1:0]      rsp_free_total
);

   localparam int LW   = $clog2(PAGES + 1);
   localparam int AW   = $clog2(PAGES);
   localparam int OW   = $clog2(MAX_ORDER_P + 1);
   localparam int ROWS = (PAGES + FLAG_W - 1) / FLAG_W;
   localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int DW0  = (LW > MAX_ORDER_P + 2) ? LW : MAX_ORDER_P + 2;
   localparam int DW   = ((DW0 > CNT_W + 1) ? DW0 : CNT_W + 1) + 1;
   localparam logic [DW-1:0] ONE   = DW'(1);
   localparam logic [DW-1:0] NIL_D = DW'(PAGES);
   localparam logic [LW-1:0] NIL_L = LW'(PAGES);
   localparam logic [OW-1:0] MAXO  = OW'(MAX_ORDER_P);

   // Storage
   logic [LW-1:0]     next_mem  [PAGES];
   logic [LW-1:0]     prev_mem  [PAGES];
   logic [OW-1:0]     order_mem [PAGES];
   logic [FLAG_W-1:0] flag_mem  [ROWS];
   logic [LW-1:0]     heads_ff  [MAX_ORDER_P+1];

   logic [LW-1:0]     next_rd_ff, prev_rd_ff;
   logic [OW-1:0]     order_rd_ff;
   logic [FLAG_W-1:0] flag_rd_ff;

   // Transaction and walk registers
   logic [1:0]       func_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DW-1:0]    p_ff, n_ff, bp_ff, x_ff, where_ff, total_ff, region_ff;
   logic [LW-1:0]    hold_ff;
   logic [OW-1:0]    k_ff, c_ff, bk_ff, xk_ff, j_ff;
   logic [RAW-1:0]   row_ff;
   logic             ok_ff;
   logic             rsp_valid_ff;
   logic             rsp_ok_ff;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [CNT_W-1:0] rsp_tot_ff;

   // Derived values
   logic [DW-1:0] idx_d, cnt_d, sat_d, rem_d, k_pow, h_d, b_d, end_d, row_d, nx_d, pv_d;
   logic [DW-1:0] head_d;
   logic [OW-1:0] head_sel;
   logic [LW-1:0] head_rd;
   logic [FLAG_W-1:0] ov_mask;

   assign idx_d    = DW'(idx_ff);
   assign cnt_d    = DW'(cnt_ff);
   assign sat_d    = (cnt_d > NIL_D) ? NIL_D : cnt_d;
   assign rem_d    = region_ff - idx_d;
   assign k_pow    = ONE << k_ff;
   assign h_d      = bp_ff & ~((ONE << j_ff) - ONE);
   assign b_d      = bp_ff ^ (ONE << bk_ff);
   assign end_d    = bp_ff + (ONE << bk_ff) - ONE;
   assign row_d    = DW'(row_ff);
   assign nx_d     = DW'(next_rd_ff);
   assign pv_d     = DW'(prev_rd_ff);
   assign head_sel = (cmd.op == ST_SRCH) ? c_ff : bk_ff;
   assign head_rd  = heads_ff[head_sel];
   assign head_d   = DW'(head_rd);
   assign ov_mask  = (int'(bk_ff) >= FLAG_SH) ? {FLAG_W{1'b1}} :
      (~({FLAG_W{1'b1}} << (FLAG_W'(1) << bk_ff)) << bp_ff[FLAG_SH-1:0]);

   // Status to the sequencer
   always_comb begin
      st.func       = func_ff;
      st.free_go    = (idx_d < region_ff) && (cnt_ff != '0);
      st.alloc_bad  = (cnt_ff == '0) || (cnt_d > (ONE << MAXO));
      st.clr_last   = (row_ff == RAW'(ROWS - 1));
      st.ak_more    = (k_pow < n_ff);
      st.head_hit   = (head_d < NIL_D);
      st.c_last     = (c_ff == MAXO);
      st.split_more = (c_ff > k_ff);
      st.n_zero     = (n_ff == '0);
      st.frk_more   = (k_ff < MAXO) && !p_ff[k_ff] && ((k_pow << 1) <= n_ff);
      st.ov_hit     = |(flag_rd_ff & ov_mask);
      st.ov_last    = ((end_d >> FLAG_SH) == row_d) || (row_ff == RAW'(ROWS - 1));
      st.ov2_hit    = flag_rd_ff[h_d[FLAG_SH-1:0]] && ((bp_ff - h_d) < (ONE << order_rd_ff));
      st.j_last     = (j_ff == MAXO);
      st.m_try      = (bk_ff < MAXO) && (b_d < region_ff);
      st.m_hit      = flag_rd_ff[b_d[FLAG_SH-1:0]] && (order_rd_ff == bk_ff);
      st.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // Memory port selection
   logic [DW-1:0]     flag_ra_d;
   logic [RAW-1:0]    flag_ra, flag_wa;
   logic              flag_we;
   logic [FLAG_W-1:0] flag_wd;
   logic [AW-1:0]     order_ra, next_wa, prev_wa;
   logic              next_we, prev_we;
   logic [LW-1:0]     next_wd, prev_wd;

   always_comb begin
      unique case (cmd.op)
         ST_OV2_RD: flag_ra_d = h_d;
         ST_M_TEST: flag_ra_d = b_d;
         ST_U_RD:   flag_ra_d = x_ff;
         default:   flag_ra_d = bp_ff;
      endcase
      flag_ra  = (cmd.op == ST_OV_RD) ? row_ff : flag_ra_d[RAW+FLAG_SH-1:FLAG_SH];
      order_ra = (cmd.op == ST_M_TEST) ? b_d[AW-1:0] : h_d[AW-1:0];

      flag_we = 1'b0;
      flag_wa = row_ff;
      flag_wd = '0;
      next_we = 1'b0;
      next_wa = bp_ff[AW-1:0];
      next_wd = head_rd;
      prev_we = 1'b0;
      prev_wa = bp_ff[AW-1:0];
      prev_wd = NIL_L;
      unique case (cmd.op)
         ST_CLR, ST_RCLR: begin
            flag_we = 1'b1;
         end
         ST_U_W: begin
            flag_we = 1'b1;
            flag_wa = x_ff[RAW+FLAG_SH-1:FLAG_SH];
            flag_wd = flag_rd_ff & ~(FLAG_W'(1) << x_ff[FLAG_SH-1:0]);
            next_we = (pv_d < NIL_D);
            next_wa = prev_rd_ff[AW-1:0];
            next_wd = next_rd_ff;
            prev_we = (nx_d < NIL_D);
            prev_wa = next_rd_ff[AW-1:0];
            prev_wd = prev_rd_ff;
         end
         ST_P_W: begin
            flag_we = 1'b1;
            flag_wa = bp_ff[RAW+FLAG_SH-1:FLAG_SH];
            flag_wd = flag_rd_ff | (FLAG_W'(1) << bp_ff[FLAG_SH-1:0]);
            next_we = 1'b1;
            prev_we = 1'b1;
         end
         ST_P_W2: begin
            prev_we = (DW'(hold_ff) < NIL_D);
            prev_wa = hold_ff[AW-1:0];
            prev_wd = bp_ff[LW-1:0];
         end
         default: begin
         end
      endcase
   end

   // Memories
   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= flag_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (cmd.op == ST_P_W) order_mem[bp_ff[AW-1:0]] <= bk_ff;
      flag_rd_ff  <= flag_mem[flag_ra];
      order_rd_ff <= order_mem[order_ra];
      next_rd_ff  <= next_mem[x_ff[AW-1:0]];
      prev_rd_ff  <= prev_mem[x_ff[AW-1:0]];
   end

   // Control state: region, list heads, free total, row counter, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         region_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= MAX_ORDER_P; i++) heads_ff[i] <= NIL_L;
      end else begin
         unique case (cmd.op)
            ST_DISP: begin
               if (func_ff == FUNC_INIT) begin
                  region_ff <= sat_d;
                  total_ff  <= '0;
                  row_ff    <= '0;
                  for (int i = 0; i <= MAX_ORDER_P; i++) heads_ff[i] <= NIL_L;
               end
            end
            ST_CLR, ST_RCLR, ST_OV_CK: row_ff <= row_ff + RAW'(1);
            ST_FRK: if (!st.frk_more) row_ff <= p_ff[RAW+FLAG_SH-1:FLAG_SH];
            ST_U_W: begin
               if (pv_d >= NIL_D) heads_ff[xk_ff] <= next_rd_ff;
               total_ff <= total_ff - (ONE << xk_ff);
            end
            ST_P_W: begin
               heads_ff[bk_ff] <= bp_ff[LW-1:0];
               total_ff        <= total_ff + (ONE << bk_ff);
            end
            default: begin
            end
         endcase
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // Walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         idx_ff  <= req_first_page;
         cnt_ff  <= req_num_pages;
      end
      unique case (cmd.op)
         ST_DISP: begin
            ok_ff    <= 1'b1;
            where_ff <= '0;
            unique case (func_ff)
               FUNC_FREE: begin
                  p_ff <= idx_d;
                  n_ff <= (cnt_d > rem_d) ? rem_d : cnt_d;
               end
               FUNC_INIT: begin
                  p_ff <= '0;
                  n_ff <= sat_d;
               end
               FUNC_ALLOC: begin
                  n_ff <= cnt_d;
                  k_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         ST_FAIL: begin
            ok_ff    <= 1'b0;
            where_ff <= '0;
         end
         ST_AK: begin
            if (st.ak_more) k_ff <= k_ff + OW'(1);
            else c_ff <= k_ff;
         end
         ST_SRCH: begin
            if (st.head_hit) begin
               x_ff  <= head_d;
               xk_ff <= c_ff;
               p_ff  <= head_d;
            end else if (!st.c_last) begin
               c_ff <= c_ff + OW'(1);
            end
         end
         ST_SPLIT: begin
            if (st.split_more) begin
               c_ff  <= c_ff - OW'(1);
               bp_ff <= p_ff + (ONE << (c_ff - OW'(1)));
               bk_ff <= c_ff - OW'(1);
            end else begin
               // allocation done: free the unused tail of the block
               where_ff <= p_ff;
               p_ff     <= p_ff + n_ff;
               n_ff     <= k_pow - n_ff;
            end
         end
         ST_FR: k_ff <= '0;
         ST_FRK: begin
            if (st.frk_more) begin
               k_ff <= k_ff + OW'(1);
            end else begin
               bp_ff <= p_ff;
               bk_ff <= k_ff;
            end
         end
         ST_OV_CK:  j_ff <= OW'(1);
         ST_OV2_CK: j_ff <= j_ff + OW'(1);
         ST_M_CK: begin
            x_ff  <= b_d;
            xk_ff <= bk_ff;
         end
         ST_M_UP: begin
            bp_ff <= bp_ff & b_d;
            bk_ff <= bk_ff + OW'(1);
         end
         ST_P_W: hold_ff <= head_rd;
         ST_FNX: begin
            p_ff <= p_ff + k_pow;
            n_ff <= n_ff - k_pow;
         end
         default: begin
         end
      endcase
      if (cmd.rsp_load) begin
         rsp_ok_ff  <= ok_ff;
         rsp_idx_ff <= where_ff[IDX_W-1:0];
         rsp_tot_ff <= total_ff[CNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_alloc_index = rsp_idx_ff;
   assign rsp_free_total  = rsp_tot_ff;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
module tb_top;
   import bpa_pkg::*;

   localparam int NPG    = 4096;
   localparam int MAXO   = 12;
   localparam int NRAND  = 1700;
   localparam int HOLD_N = 3000;

   typedef struct {
      logic [1:0]       func;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] count;
   } page_req_type;

   typedef struct {
      logic             ok;
      logic [IDX_W-1:0] index;
      logic [CNT_W-1:0] total;
   } page_rsp_type;

   typedef struct {
      int base;
      int len;
   } live_span_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic [1:0]       req_func = FUNC_ALLOC;
   logic [IDX_W-1:0] req_first_page = '0;
   logic [CNT_W-1:0] req_num_pages = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic             rsp_ok;
   logic [IDX_W-1:0] rsp_alloc_index;
   logic [CNT_W-1:0] rsp_free_total;

   buddy_page_allocator_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_first_page(req_first_page), .req_num_pages(req_num_pages),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_alloc_index(rsp_alloc_index), .rsp_free_total(rsp_free_total)
   );

   page_req_type  req_backlog[$];
   page_rsp_type  expected_grants[$];
   live_span_type live_spans[$];
   int         errors = 0;
   int         accepted = 0;
   int         total_items = 0;
   bit         gen_done = 0;
   int         hold_left = 0;
   bit         pressure_done = 0;

   // allocator shadow state
   int next_pg[NPG];
   int prev_pg[NPG];
   int blk_order[NPG];
   bit head_free[NPG];
   int order_head[MAXO+1];
   int order_blocks[MAXO+1];
   int region_pages;

   function automatic void shadow_clear();
      for (int i = 0; i < NPG; i++) begin
         next_pg[i] = 0;
         prev_pg[i] = 0;
         blk_order[i] = 0;
         head_free[i] = 0;
      end
      for (int o = 0; o <= MAXO; o++) begin
         order_head[o] = NPG;
         order_blocks[o] = 0;
      end
      region_pages = 0;
   endfunction

   function automatic void list_push(int p, int k);
      int h;
      h = order_head[k];
      next_pg[p] = h;
      prev_pg[p] = NPG;
      if (h < NPG) prev_pg[h] = p;
      order_head[k] = p;
      order_blocks[k]++;
      head_free[p] = 1;
      blk_order[p] = k;
   endfunction

   function automatic void list_unlink(int p, int k);
      int nx, pv;
      nx = next_pg[p];
      pv = prev_pg[p];
      if (pv < NPG) next_pg[pv] = nx;
      else order_head[k] = nx;
      if (nx < NPG) prev_pg[nx] = pv;
      if (order_blocks[k] != 0) order_blocks[k]--;
      head_free[p] = 0;
   endfunction

   // true when any page of the block is already covered by a free block
   function automatic bit touches_free(int p, int k);
      int h;
      for (int i = p; i < p + (1 << k) && i < NPG; i++)
         if (head_free[i]) return 1;
      for (int j = 1; j <= MAXO; j++) begin
         h = p & ~((1 << j) - 1);
         if (h < NPG && head_free[h] && (p - h) < (1 << blk_order[h])) return 1;
      end
      return 0;
   endfunction

   function automatic void give_back(int p, int k);
      int b;
      if (p >= NPG || touches_free(p, k)) return;
      while (k < MAXO) begin
         b = p ^ (1 << k);
         if (b >= region_pages || !head_free[b] || blk_order[b] != k) break;
         list_unlink(b, k);
         p &= b;
         k++;
      end
      list_push(p, k);
   endfunction

   function automatic void give_back_range(int p, int n);
      int k;
      while (n > 0) begin
         k = 0;
         while (k < MAXO && (p & (1 << k)) == 0 && (2 << k) <= n) k++;
         give_back(p, k);
         p += 1 << k;
         n -= 1 << k;
      end
   endfunction

   function automatic bit take_pages(int n, output int where);
      int k, c, p;
      k = 0;
      where = 0;
      if (n == 0 || n > (1 << MAXO)) return 0;
      while ((1 << k) < n) k++;
      for (c = k; c <= MAXO; c++)
         if (order_head[c] < NPG) break;
      if (c > MAXO) return 0;
      p = order_head[c];
      list_unlink(p, c);
      while (c > k) begin
         c--;
         list_push(p + (1 << c), c);
      end
      if (n < (1 << k)) give_back_range(p + n, (1 << k) - n);
      where = p;
      return 1;
   endfunction

   // apply one request to the shadow and return the expected response
   function automatic page_rsp_type buddy_apply(page_req_type r);
      page_rsp_type e;
      int        where, n, t;
      e.ok = 1'b1;
      where = 0;
      n = r.count;
      case (r.func)
         FUNC_ALLOC: begin
            if (!take_pages(n, where)) begin
               e.ok = 1'b0;
               where = 0;
            end
         end
         FUNC_FREE: begin
            if (r.index < region_pages && n > 0) begin
               if (n > region_pages - r.index) n = region_pages - r.index;
               give_back_range(r.index, n);
            end
         end
         FUNC_INIT: begin
            shadow_clear();
            if (n > NPG) n = NPG;
            region_pages = n;
            give_back_range(0, n);
         end
         default: ;
      endcase
      t = 0;
      for (int o = 0; o <= MAXO; o++) t += order_blocks[o] << o;
      if (t > NPG) t = NPG;
      e.index = where[IDX_W-1:0];
      e.total = t[CNT_W-1:0];
      return e;
   endfunction

   task automatic queue_req(input logic [1:0] f, input int idx, input int n);
      page_req_type r;
      page_rsp_type e;
      r.func = f;
      r.index = idx[IDX_W-1:0];
      r.count = n[CNT_W-1:0];
      e = buddy_apply(r);
      if (f == FUNC_INIT) live_spans.delete();
      if (f == FUNC_ALLOC && e.ok) live_spans.push_back('{e.index, r.count});
      req_backlog.push_back(r);
      expected_grants.push_back(e);
      total_items++;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
      errors++;
   endtask

   // clock and reset
   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // stimulus: directed corners, then random traffic
   initial begin
      int r, n, i;
      live_span_type s;
      shadow_clear();
      queue_req(FUNC_ALLOC, 0, 1);
      queue_req(FUNC_FREE, 3, 4);
      queue_req(FUNC_INIT, 0, 4096);
      queue_req(FUNC_ALLOC, 0, 1);
      queue_req(FUNC_ALLOC, 0, 4096);
      queue_req(FUNC_ALLOC, 0, 0);
      queue_req(FUNC_ALLOC, 0, 8191);
      queue_req(FUNC_FREE, 0, 1);
      queue_req(FUNC_ALLOC, 4095, 4096);
      queue_req(FUNC_FREE, 0, 4096);
      queue_req(FUNC_FREE, 0, 1);
      queue_req(FUNC_FREE, 4095, 8191);
      queue_req(FUNC_FREE, 7, 0);
      queue_req(2'd3, 4095, 8191);
      queue_req(FUNC_INIT, 0, 0);
      queue_req(FUNC_ALLOC, 0, 1);
      queue_req(FUNC_FREE, 5, 3);
      queue_req(FUNC_INIT, 4095, 8191);
      queue_req(FUNC_ALLOC, 0, 3);
      queue_req(FUNC_ALLOC, 0, 2047);
      queue_req(FUNC_INIT, 0, 1000);
      queue_req(FUNC_ALLOC, 0, 700);
      queue_req(FUNC_FREE, 4000, 10);
      queue_req(FUNC_FREE, 990, 100);
      queue_req(FUNC_INIT, 0, 4096);

      for (int k = 0; k < NRAND; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : 4096;
            queue_req(FUNC_INIT, $urandom_range(0, 4095), n);
         end else if (r < 48) begin
            case ($urandom_range(0, 19))
               0:       n = 0;
               1:       n = $urandom_range(4097, 8191);
               2, 3:    n = $urandom_range(1, 4096);
               default: n = $urandom_range(1, 64);
            endcase
            queue_req(FUNC_ALLOC, $urandom_range(0, 4095), n);
         end else if (r < 88 && live_spans.size() > 0) begin
            // free a live allocation, sometimes only its tail
            i = $urandom_range(0, live_spans.size() - 1);
            s = live_spans[i];
            live_spans.delete(i);
            if (s.len > 1 && $urandom_range(0, 4) == 0) begin
               n = $urandom_range(1, s.len - 1);
               queue_req(FUNC_FREE, s.base + n, s.len - n);
               live_spans.push_back('{s.base, n});
            end else begin
               queue_req(FUNC_FREE, s.base, s.len);
            end
         end else if (r < 97) begin
            queue_req(FUNC_FREE, $urandom_range(0, 4095), $urandom_range(0, 8191));
         end else begin
            queue_req(2'd3, $urandom_range(0, 4095), $urandom_range(0, 8191));
         end
      end
      gen_done = 1;
   end

   // idle phase from progress: none, sender, receiver, both
   function automatic int idle_phase();
      if (total_items == 0) return 0;
      return (accepted * 4) / total_items;
   endfunction

   // request driver
   always @(posedge clock) begin
      page_req_type r;
      bit        idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) accepted++;
         if (!req_valid || req_ready) begin
            case (idle_phase())
               1:       idle = ($urandom_range(0, 99) < 75);
               3:       idle = ($urandom_range(0, 99) < 28);
               default: idle = 0;
            endcase
            if (gen_done && req_backlog.size() > 0 && !idle) begin
               r = req_backlog.pop_front();
               req_func <= r.func;
               req_first_page <= r.index;
               req_num_pages <= r.count;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response acceptor, with one long hold-off early on
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!pressure_done && accepted >= 30) begin
         pressure_done <= 1;
         hold_left <= HOLD_N;
         rsp_ready <= 1'b0;
      end else begin
         case (idle_phase())
            2:       rsp_ready <= ($urandom_range(0, 99) >= 75);
            3:       rsp_ready <= ($urandom_range(0, 99) >= 28);
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // response monitor
   always @(posedge clock) begin
      page_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_grants.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            e = expected_grants.pop_front();
            if (rsp_ok !== e.ok) report_mismatch("ok", rsp_ok, e.ok);
            if (rsp_alloc_index !== e.index)
               report_mismatch("alloc_index", rsp_alloc_index, e.index);
            if (rsp_free_total !== e.total)
               report_mismatch("free_total", rsp_free_total, e.total);
         end
      end
   end

   // end of run
   initial begin
      wait (gen_done && !reset);
      while (req_backlog.size() > 0 || req_valid || expected_grants.size() > 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
      if (errors == 0 && expected_grants.size() == 0)
         $display("buddy_page_allocator_unit regression: pass");
      else
         $display("buddy_page_allocator_unit regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #500_000_000;
      $display("buddy_page_allocator_unit regression: fail");
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ctrl.sv
sv/bpa_dpath.sv
sv/buddy_page_allocator_unit.sv
sim/tb_top.sv
